// ===== design/ffsa_pkg.sv =====
// shared types, constants and helpers of the first-fit segment allocator
// no dependencies
package ffsa_pkg;

  localparam int unsigned MaxSegmentsDefault = 64;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ValW    = 34;
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PgW     = 21;

  localparam logic [DataW-1:0] BlockSizeReset = 32'd134217728;
  localparam logic [PgW-1:0]   PageGranReset  = 21'd1;

  localparam logic [KindW-1:0] KindFree    = 3'd0;
  localparam logic [KindW-1:0] KindBuffer  = 3'd1;
  localparam logic [KindW-1:0] KindImage   = 3'd2;
  localparam logic [KindW-1:0] KindLinear  = 3'd3;
  localparam logic [KindW-1:0] KindOptimal = 3'd4;

  localparam logic [StatusW-1:0] StatusOk     = 2'd0;
  localparam logic [StatusW-1:0] StatusNoFit  = 2'd1;
  localparam logic [StatusW-1:0] StatusBadTag = 2'd2;
  localparam logic [StatusW-1:0] StatusFull   = 2'd3;

  localparam logic RegBlockSize = 1'b0;
  localparam logic RegPageGran  = 1'b1;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic {AluAdd, AluSub} alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
    logic [ValW-1:0] mask;
  } alu_req_t;

  typedef struct packed {
    logic [DataW-1:0] start;
    logic [DataW-1:0] length;
    logic [KindW-1:0] kind;
    logic [DataW-1:0] pad;
    logic [DataW-1:0] tag;
  } seg_t;

  localparam int unsigned SegW = $bits(seg_t);

  function automatic logic kinds_conflict(logic [KindW-1:0] k1, logic [KindW-1:0] k2);
    logic [KindW-1:0] lo;
    logic [KindW-1:0] hi;
    logic             r;
    lo = (k1 < k2) ? k1 : k2;
    hi = (k1 < k2) ? k2 : k1;
    r  = 1'b0;
    unique case (lo)
      KindBuffer: r = (hi == KindImage) || (hi == KindOptimal);
      KindImage:  r = (hi == KindImage) || (hi == KindLinear) || (hi == KindOptimal);
      KindLinear: r = (hi == KindOptimal);
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ffsa_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
module ffsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ffsa_alu.sv =====
// shared add/subtract unit with result masking
// depends on ffsa_pkg
module ffsa_alu (
  input  ffsa_pkg::alu_req_t          req_i,
  output logic [ffsa_pkg::ValW-1:0]   res_o
);

  logic [ffsa_pkg::ValW-1:0] opb;
  logic [ffsa_pkg::ValW-1:0] sum;

  always_comb begin
    opb = (req_i.op == ffsa_pkg::AluSub) ? ~req_i.b : req_i.b;
    sum = req_i.a + opb + ffsa_pkg::ValW'(req_i.op == ffsa_pkg::AluSub);
    res_o = sum & ~req_i.mask;
  end

endmodule

// ===== design/first_fit_segment_allocator.sv =====
// first-fit segment allocator: sequencer, segment table and shared alu
// depends on ffsa_pkg, ffsa_ram, ffsa_alu
// allocate: setup checks, a walk over the entries, an alignment and page check per free
//   candidate, entries moved up one by one on a split, then commit and output
// free: load, a walk over the entries, neighbour sums, entries moved down on a merge, output
// one request at a time; the alu and the single table read port set the pace
// reset: table holds one free segment covering the block, no clearing pass
module first_fit_segment_allocator #(
  parameter int unsigned MaxSegments = ffsa_pkg::MaxSegmentsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [ffsa_pkg::DataW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [ffsa_pkg::DataW-1:0]    req_size_i,
  input  logic [ffsa_pkg::DataW-1:0]    req_align_i,
  input  logic [ffsa_pkg::KindW-1:0]    kind_i,
  input  logic [ffsa_pkg::DataW-1:0]    free_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffsa_pkg::StatusW-1:0]  status_o,
  output logic [ffsa_pkg::DataW-1:0]    granted_offset_o,
  output logic [ffsa_pkg::DataW-1:0]    granted_size_o,
  output logic [ffsa_pkg::DataW-1:0]    granted_tag_o
);

  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam int unsigned SrcW = CntW + 1;
  localparam int unsigned VW   = ffsa_pkg::ValW;
  localparam int unsigned DW   = ffsa_pkg::DataW;

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StA0     = 5'd1;
  localparam logic [4:0] StA1     = 5'd2;
  localparam logic [4:0] StA2     = 5'd3;
  localparam logic [4:0] StA3     = 5'd4;
  localparam logic [4:0] StLoad0  = 5'd5;
  localparam logic [4:0] StLoad1  = 5'd6;
  localparam logic [4:0] StEval   = 5'd7;
  localparam logic [4:0] StPrev   = 5'd8;
  localparam logic [4:0] StPchk   = 5'd9;
  localparam logic [4:0] StEnd    = 5'd10;
  localparam logic [4:0] StNeed   = 5'd11;
  localparam logic [4:0] StFit    = 5'd12;
  localparam logic [4:0] StNchk   = 5'd13;
  localparam logic [4:0] StSplit  = 5'd14;
  localparam logic [4:0] StShUp   = 5'd15;
  localparam logic [4:0] StRem    = 5'd16;
  localparam logic [4:0] StTag    = 5'd17;
  localparam logic [4:0] StPad    = 5'd18;
  localparam logic [4:0] StUsed   = 5'd19;
  localparam logic [4:0] StFOff   = 5'd20;
  localparam logic [4:0] StFUsed  = 5'd21;
  localparam logic [4:0] StFSum1  = 5'd22;
  localparam logic [4:0] StFSum2  = 5'd23;
  localparam logic [4:0] StFWrite = 5'd24;
  localparam logic [4:0] StShDn   = 5'd25;
  localparam logic [4:0] StFin    = 5'd26;
  localparam logic [4:0] StDone   = 5'd27;

  logic [4:0] state_q, state_d;

  logic                         op_q, op_d;
  logic [DW-1:0]                size_q, size_d;
  logic [DW-1:0]                align_q, align_d;
  logic [ffsa_pkg::KindW-1:0]   kind_q, kind_d;
  logic [DW-1:0]                ftag_q, ftag_d;
  logic [DW-1:0]                am_q, am_d;
  logic [ffsa_pkg::PgW-1:0]     gm_q, gm_d;
  logic [IdxW-1:0]              i_q, i_d;
  logic [IdxW-1:0]              j_q, j_d;
  ffsa_pkg::seg_t               cur_q, cur_d;
  ffsa_pkg::seg_t               prev_q, prev_d;
  logic [VW-1:0]                off_q, off_d;
  logic [VW-1:0]                end_q, end_d;
  logic [VW-1:0]                need_q, need_d;
  logic [VW-1:0]                t_q, t_d;
  logic                         pf_q, pf_d;
  logic                         nf_q, nf_d;

  logic [CntW-1:0]              count_q, count_d;
  logic [DW-1:0]                used_q, used_d;
  logic [DW-1:0]                ntag_q, ntag_d;
  logic [DW-1:0]                bs_q;
  logic [ffsa_pkg::PgW-1:0]     pg_q;
  logic                         e0_init_q;
  logic                         rd0_q;

  logic [ffsa_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [DW-1:0]                res_off_q, res_off_d;
  logic [DW-1:0]                res_size_q, res_size_d;
  logic [DW-1:0]                res_tag_q, res_tag_d;

  logic                         out_valid_q;
  logic [ffsa_pkg::StatusW-1:0] out_status_q;
  logic [DW-1:0]                out_off_q;
  logic [DW-1:0]                out_size_q;
  logic [DW-1:0]                out_tag_q;

  logic                         ram_we;
  logic [IdxW-1:0]              ram_waddr;
  ffsa_pkg::seg_t               ram_wdata;
  logic                         ram_re;
  logic [IdxW-1:0]              ram_raddr;
  logic [ffsa_pkg::SegW-1:0]    ram_rdata;

  ffsa_pkg::alu_req_t           alu_req;
  logic [VW-1:0]                alu_res;

  ffsa_pkg::seg_t               rd;
  ffsa_pkg::seg_t               init_seg;
  logic                         has_next;
  logic                         adv;
  logic                         fin;
  logic [ffsa_pkg::StatusW-1:0] fin_status;
  logic [DW-1:0]                fin_off;
  logic [DW-1:0]                fin_size;
  logic [DW-1:0]                fin_tag;
  logic [SrcW-1:0]              src;
  logic [1:0]                   rm;
  logic [VW-1:0]                gm_ext;
  logic                         load_out;

  ffsa_ram #(
    .Width (ffsa_pkg::SegW),
    .Depth (MaxSegments)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffsa_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  always_comb begin
    init_seg        = '0;
    init_seg.length = bs_q;
    init_seg.kind   = ffsa_pkg::KindFree;
    rd       = (rd0_q && e0_init_q) ? init_seg : ffsa_pkg::seg_t'(ram_rdata);
    has_next = (CntW'(i_q) + CntW'(1)) < count_q;
    gm_ext   = VW'(gm_q);
    rm       = {1'b0, pf_q} + {1'b0, nf_q};
    src      = SrcW'(i_q) + SrcW'(1) + SrcW'(nf_q);
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    size_d       = size_q;
    align_d      = align_q;
    kind_d       = kind_q;
    ftag_d       = ftag_q;
    am_d         = am_q;
    gm_d         = gm_q;
    i_d          = i_q;
    j_d          = j_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    off_d        = off_q;
    end_d        = end_q;
    need_d       = need_q;
    t_d          = t_q;
    pf_d         = pf_q;
    nf_d         = nf_q;
    count_d      = count_q;
    used_d       = used_q;
    ntag_d       = ntag_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_size_d   = res_size_q;
    res_tag_d    = res_tag_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = cur_q;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    alu_req.op   = ffsa_pkg::AluAdd;
    alu_req.a    = '0;
    alu_req.b    = '0;
    alu_req.mask = '0;
    adv          = 1'b0;
    fin          = 1'b0;
    fin_status   = ffsa_pkg::StatusOk;
    fin_off      = '0;
    fin_size     = '0;
    fin_tag      = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          size_d  = req_size_i;
          align_d = req_align_i;
          kind_d  = kind_i;
          ftag_d  = free_tag_i;
          state_d = (operation_i == ffsa_pkg::OpFree) ? StLoad0 : StA0;
        end
      end
      StA0: begin
        if (size_q == '0 || kind_q < ffsa_pkg::KindBuffer || kind_q > ffsa_pkg::KindOptimal) begin
          fin        = 1'b1;
          fin_status = ffsa_pkg::StatusNoFit;
        end else begin
          alu_req.op = ffsa_pkg::AluSub;
          alu_req.a  = VW'(align_q);
          alu_req.b  = VW'(1);
          am_d       = (align_q != '0) ? ((align_q ^ alu_res[DW-1:0]) >> 1) : '0;
          state_d    = StA1;
        end
      end
      StA1: begin
        alu_req.op = ffsa_pkg::AluSub;
        alu_req.a  = VW'(pg_q);
        alu_req.b  = VW'(1);
        gm_d       = (pg_q != '0) ? ((pg_q ^ alu_res[ffsa_pkg::PgW-1:0]) >> 1) : '0;
        state_d    = StA2;
      end
      StA2: begin
        alu_req.op = ffsa_pkg::AluSub;
        alu_req.a  = VW'(bs_q);
        alu_req.b  = VW'(used_q);
        t_d        = alu_res;
        state_d    = StA3;
      end
      StA3: begin
        if (t_q < VW'(size_q)) begin
          fin        = 1'b1;
          fin_status = ffsa_pkg::StatusNoFit;
        end else begin
          state_d = StLoad0;
        end
      end
      StLoad0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        i_d       = '0;
        state_d   = StLoad1;
      end
      StLoad1: begin
        cur_d     = rd;
        ram_re    = 1'b1;
        ram_raddr = IdxW'(1);
        state_d   = StEval;
      end
      StEval: begin
        if (op_q == ffsa_pkg::OpFree) begin
          if (cur_q.kind != ffsa_pkg::KindFree && cur_q.tag == ftag_q) begin
            state_d = StFOff;
          end else begin
            adv = 1'b1;
          end
        end else if (cur_q.kind != ffsa_pkg::KindFree || size_q > cur_q.length) begin
          adv = 1'b1;
        end else begin
          alu_req.a    = VW'(cur_q.start);
          alu_req.b    = VW'(am_q);
          alu_req.mask = VW'(am_q);
          off_d        = alu_res;
          state_d      = StPrev;
        end
      end
      StPrev: begin
        if (i_q != '0 && gm_q != '0 && ffsa_pkg::kinds_conflict(prev_q.kind, kind_q)) begin
          alu_req.op = ffsa_pkg::AluSub;
          alu_req.a  = VW'(cur_q.start);
          alu_req.b  = VW'(1);
          t_d        = alu_res;
          state_d    = StPchk;
        end else begin
          state_d = StEnd;
        end
      end
      StPchk: begin
        if (((t_q ^ off_q) & ~gm_ext) == '0) begin
          alu_req.a    = off_q;
          alu_req.b    = gm_ext;
          alu_req.mask = gm_ext;
          off_d        = alu_res;
        end
        state_d = StEnd;
      end
      StEnd: begin
        alu_req.a = off_q;
        alu_req.b = VW'(size_q);
        end_d     = alu_res;
        state_d   = StNeed;
      end
      StNeed: begin
        alu_req.op = ffsa_pkg::AluSub;
        alu_req.a  = end_q;
        alu_req.b  = VW'(cur_q.start);
        need_d     = alu_res;
        state_d    = StFit;
      end
      StFit: begin
        if (need_q > VW'(cur_q.length)) begin
          adv = 1'b1;
        end else if (gm_q != '0 && has_next && ffsa_pkg::kinds_conflict(kind_q, rd.kind)) begin
          alu_req.op = ffsa_pkg::AluSub;
          alu_req.a  = end_q;
          alu_req.b  = VW'(1);
          t_d        = alu_res;
          state_d    = StNchk;
        end else begin
          state_d = StSplit;
        end
      end
      StNchk: begin
        if (((t_q ^ VW'(rd.start)) & ~gm_ext) == '0) begin
          adv = 1'b1;
        end else begin
          state_d = StSplit;
        end
      end
      StSplit: begin
        if (VW'(cur_q.length) > need_q) begin
          if (count_q >= CntW'(MaxSegments)) begin
            fin        = 1'b1;
            fin_status = ffsa_pkg::StatusFull;
          end else if (has_next) begin
            ram_re    = 1'b1;
            ram_raddr = IdxW'(count_q - CntW'(1));
            j_d       = IdxW'(count_q - CntW'(1));
            state_d   = StShUp;
          end else begin
            state_d = StRem;
          end
        end else begin
          state_d = StPad;
        end
      end
      StShUp: begin
        ram_we    = 1'b1;
        ram_waddr = j_q + IdxW'(1);
        ram_wdata = rd;
        if (CntW'(j_q) > CntW'(i_q) + CntW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = j_q - IdxW'(1);
          j_d       = j_q - IdxW'(1);
        end else begin
          state_d = StRem;
        end
      end
      StRem: begin
        alu_req.op       = ffsa_pkg::AluSub;
        alu_req.a        = VW'(cur_q.length);
        alu_req.b        = need_q;
        ram_we           = 1'b1;
        ram_waddr        = i_q + IdxW'(1);
        ram_wdata.start  = end_q[DW-1:0];
        ram_wdata.length = alu_res[DW-1:0];
        ram_wdata.kind   = ffsa_pkg::KindFree;
        ram_wdata.pad    = '0;
        ram_wdata.tag    = ntag_q;
        state_d          = StTag;
      end
      StTag: begin
        alu_req.a = VW'(ntag_q);
        alu_req.b = VW'(1);
        ntag_d    = alu_res[DW-1:0];
        count_d   = count_q + CntW'(1);
        state_d   = StPad;
      end
      StPad: begin
        alu_req.op       = ffsa_pkg::AluSub;
        alu_req.a        = off_q;
        alu_req.b        = VW'(cur_q.start);
        ram_we           = 1'b1;
        ram_waddr        = i_q;
        ram_wdata.start  = cur_q.start;
        ram_wdata.length = need_q[DW-1:0];
        ram_wdata.kind   = kind_q;
        ram_wdata.pad    = alu_res[DW-1:0];
        ram_wdata.tag    = cur_q.tag;
        state_d          = StUsed;
      end
      StUsed: begin
        alu_req.a = VW'(used_q);
        alu_req.b = need_q;
        used_d    = alu_res[DW-1:0];
        fin       = 1'b1;
        fin_off   = off_q[DW-1:0];
        fin_size  = size_q;
        fin_tag   = cur_q.tag;
      end
      StFOff: begin
        alu_req.a = VW'(cur_q.start);
        alu_req.b = VW'(cur_q.pad);
        off_d     = alu_res;
        state_d   = StFUsed;
      end
      StFUsed: begin
        alu_req.op = ffsa_pkg::AluSub;
        alu_req.a  = VW'(used_q);
        alu_req.b  = VW'(cur_q.length);
        used_d     = alu_res[DW-1:0];
        pf_d       = (i_q != '0) && (prev_q.kind == ffsa_pkg::KindFree);
        nf_d       = has_next && (rd.kind == ffsa_pkg::KindFree);
        state_d    = StFSum1;
      end
      StFSum1: begin
        if (pf_q) begin
          alu_req.a = VW'(prev_q.length);
          alu_req.b = VW'(cur_q.length);
          t_d       = alu_res;
        end else begin
          t_d = VW'(cur_q.length);
        end
        state_d = StFSum2;
      end
      StFSum2: begin
        if (nf_q) begin
          alu_req.a = t_q;
          alu_req.b = VW'(rd.length);
          t_d       = alu_res;
        end
        state_d = StFWrite;
      end
      StFWrite: begin
        ram_we = 1'b1;
        if (pf_q) begin
          ram_waddr        = i_q - IdxW'(1);
          ram_wdata        = prev_q;
          ram_wdata.length = t_q[DW-1:0];
        end else begin
          ram_waddr        = i_q;
          ram_wdata        = cur_q;
          ram_wdata.length = t_q[DW-1:0];
          ram_wdata.kind   = ffsa_pkg::KindFree;
          ram_wdata.pad    = '0;
        end
        if (rm != 2'd0 && src < SrcW'(count_q)) begin
          ram_re    = 1'b1;
          ram_raddr = IdxW'(src);
          j_d       = IdxW'(src);
          state_d   = StShDn;
        end else begin
          state_d = StFin;
        end
      end
      StShDn: begin
        ram_we    = 1'b1;
        ram_waddr = j_q - IdxW'(rm);
        ram_wdata = rd;
        if (CntW'(j_q) + CntW'(1) < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = j_q + IdxW'(1);
          j_d       = j_q + IdxW'(1);
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        count_d  = count_q - CntW'(rm);
        fin      = 1'b1;
        fin_off  = off_q[DW-1:0];
        fin_size = cur_q.length;
        fin_tag  = ftag_q;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (adv) begin
      if (!has_next) begin
        fin        = 1'b1;
        fin_status = (op_q == ffsa_pkg::OpFree) ? ffsa_pkg::StatusBadTag : ffsa_pkg::StatusNoFit;
      end else begin
        prev_d    = cur_q;
        cur_d     = rd;
        i_d       = i_q + IdxW'(1);
        ram_re    = 1'b1;
        ram_raddr = i_q + IdxW'(2);
        state_d   = StEval;
      end
    end

    if (fin) begin
      res_status_d = fin_status;
      res_off_d    = fin_off;
      res_size_d   = fin_size;
      res_tag_d    = fin_tag;
      state_d      = StDone;
    end
  end

  assign load_out = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      count_q     <= CntW'(1);
      used_q      <= '0;
      ntag_q      <= DW'(1);
      bs_q        <= ffsa_pkg::BlockSizeReset;
      pg_q        <= ffsa_pkg::PageGranReset;
      e0_init_q   <= 1'b1;
      rd0_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_re) begin
        rd0_q <= (ram_raddr == '0);
      end
      if (cfg_we_i && cfg_index_i == ffsa_pkg::RegBlockSize) begin
        bs_q      <= cfg_data_i;
        count_q   <= CntW'(1);
        used_q    <= '0;
        ntag_q    <= DW'(1);
        e0_init_q <= 1'b1;
      end else begin
        count_q <= count_d;
        used_q  <= used_d;
        ntag_q  <= ntag_d;
        if (ram_we && ram_waddr == '0) begin
          e0_init_q <= 1'b0;
        end
      end
      if (cfg_we_i && cfg_index_i == ffsa_pkg::RegPageGran) begin
        pg_q <= cfg_data_i[ffsa_pkg::PgW-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    size_q       <= size_d;
    align_q      <= align_d;
    kind_q       <= kind_d;
    ftag_q       <= ftag_d;
    am_q         <= am_d;
    gm_q         <= gm_d;
    i_q          <= i_d;
    j_q          <= j_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    off_q        <= off_d;
    end_q        <= end_d;
    need_q       <= need_d;
    t_q          <= t_d;
    pf_q         <= pf_d;
    nf_q         <= nf_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_size_q   <= res_size_d;
    res_tag_q    <= res_tag_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_size_q   <= res_size_q;
      out_tag_q    <= res_tag_q;
    end
  end

  assign in_ready_o       = (state_q == StIdle);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_off_q;
  assign granted_size_o   = out_size_q;
  assign granted_tag_o    = out_tag_q;

endmodule

// ===== design/ffsa_checker.sv =====
// port-level checks of the first-fit segment allocator, bound to the top level
// depends on ffsa_pkg and first_fit_segment_allocator
module ffsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [ffsa_pkg::StatusW-1:0] status_o,
  input logic [ffsa_pkg::DataW-1:0]   granted_offset_o,
  input logic [ffsa_pkg::DataW-1:0]   granted_size_o,
  input logic [ffsa_pkg::DataW-1:0]   granted_tag_o
);

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_tag_o))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ffsa_pkg::StatusOk |->
      granted_offset_o == '0 && granted_size_o == '0 && granted_tag_o == '0)
    else $error("failed request with nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ffsa_pkg::StatusOk |-> granted_size_o != '0)
    else $error("successful request with zero size");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);

// ===== tb/tb_first_fit_segment_allocator.sv =====
// self-checking testbench of the first-fit segment allocator: random and directed requests
// against a behavioral segment-table predictor, with random idling on both channels
// depends on ffsa_pkg and first_fit_segment_allocator
module tb_first_fit_segment_allocator;
  import ffsa_pkg::*;

  localparam int unsigned NumSeg = 64;
  localparam int unsigned CycleLimit = 5000000;

  typedef struct {
    logic             op;
    logic [DataW-1:0] size;
    logic [DataW-1:0] align;
    logic [KindW-1:0] kind;
    logic [DataW-1:0] tag;
  } alloc_req_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   offset;
    logic [DataW-1:0]   size;
    logic [DataW-1:0]   tag;
  } grant_t;

  typedef struct {
    logic [DataW-1:0] start;
    logic [DataW-1:0] len;
    logic [KindW-1:0] kind;
    logic [DataW-1:0] pad;
    logic [DataW-1:0] tag;
  } segment_t;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_index_i;
  logic [DataW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, operation_i;
  logic [DataW-1:0] req_size_i, req_align_i, free_tag_i;
  logic [KindW-1:0] kind_i;
  logic out_valid_o, out_ready_i;
  logic [StatusW-1:0] status_o;
  logic [DataW-1:0] granted_offset_o, granted_size_o, granted_tag_o;

  first_fit_segment_allocator dut (.*);

  alloc_req_t pending_q[$];
  grant_t     grant_q[$];
  logic [DataW-1:0] live_tags[$];

  segment_t   seg_tbl[NumSeg];
  int         seg_cnt;
  logic [DataW-1:0] used_b, tag_next, blk_bytes;
  logic [PgW-1:0]   page_gran;

  int unsigned cycle_cnt, err_cnt, grant_cnt, ok_cnt, full_cnt;
  logic taken, calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit [63:0] low_one(bit [63:0] v);
    bit [63:0] b;
    b = v & (~v + 64'd1);
    return (b == 0) ? 64'd1 : b;
  endfunction

  function automatic bit [63:0] round_up(bit [63:0] x, bit [63:0] a);
    return (x + a - 64'd1) & ~(a - 64'd1);
  endfunction

  function automatic bit on_page(bit [63:0] as, bit [63:0] al, bit [63:0] bs, bit [63:0] g);
    bit [63:0] m;
    m = ~(g - 64'd1);
    return ((as + al - 64'd1) & m) == (bs & m);
  endfunction

  function automatic bit clash(logic [KindW-1:0] k1, logic [KindW-1:0] k2);
    logic [KindW-1:0] lo, hi;
    lo = (k1 < k2) ? k1 : k2;
    hi = (k1 < k2) ? k2 : k1;
    case (lo)
      KindBuffer: return hi == KindImage || hi == KindOptimal;
      KindImage:  return hi == KindImage || hi == KindLinear || hi == KindOptimal;
      KindLinear: return hi == KindOptimal;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic void reset_table();
    for (int j = 0; j < NumSeg; j++) seg_tbl[j] = '{default: '0};
    seg_tbl[0].len = blk_bytes;
    seg_cnt = 1;
    used_b = '0;
    tag_next = 32'd1;
  endfunction

  function automatic void merge_next(int i);
    seg_tbl[i].len += seg_tbl[i+1].len;
    for (int j = i + 1; j < seg_cnt - 1; j++) seg_tbl[j] = seg_tbl[j+1];
    seg_cnt--;
    seg_tbl[seg_cnt] = '{default: '0};
  endfunction

  function automatic grant_t place_alloc(alloc_req_t r);
    grant_t g;
    bit [63:0] sz, a, pg, off, need;
    int i;
    bit hit;
    g = '{default: '0};
    sz = r.size;
    a = low_one(r.align);
    pg = low_one(page_gran);
    hit = 1'b0;
    off = 0;
    need = 0;
    g.status = StatusNoFit;
    if (sz == 0 || r.kind < KindBuffer || r.kind > KindOptimal) return g;
    if (64'(blk_bytes) - used_b < sz) return g;
    for (i = 0; i < seg_cnt; i++) begin
      if (seg_tbl[i].kind != KindFree || sz > seg_tbl[i].len) continue;
      off = round_up(seg_tbl[i].start, a);
      if (i > 0 && pg > 1 && on_page(seg_tbl[i-1].start, seg_tbl[i-1].len, off, pg) &&
          clash(seg_tbl[i-1].kind, r.kind))
        off = round_up(off, pg);
      need = (off - seg_tbl[i].start) + sz;
      if (need > seg_tbl[i].len) continue;
      if (pg > 1 && i + 1 < seg_cnt && on_page(off, sz, seg_tbl[i+1].start, pg) &&
          clash(r.kind, seg_tbl[i+1].kind))
        continue;
      hit = 1'b1;
      break;
    end
    if (!hit) return g;
    if (seg_tbl[i].len > need) begin
      if (seg_cnt >= NumSeg) begin
        g.status = StatusFull;
        return g;
      end
      for (int j = seg_cnt; j > i + 1; j--) seg_tbl[j] = seg_tbl[j-1];
      seg_tbl[i+1].start = 32'(off + sz);
      seg_tbl[i+1].len = 32'(seg_tbl[i].len - need);
      seg_tbl[i+1].kind = KindFree;
      seg_tbl[i+1].pad = '0;
      seg_tbl[i+1].tag = tag_next;
      tag_next++;
      seg_cnt++;
    end
    seg_tbl[i].kind = r.kind;
    seg_tbl[i].len = 32'(need);
    seg_tbl[i].pad = 32'(off - seg_tbl[i].start);
    used_b += 32'(need);
    g.status = StatusOk;
    g.offset = 32'(off);
    g.size = r.size;
    g.tag = seg_tbl[i].tag;
    return g;
  endfunction

  function automatic grant_t release_seg(alloc_req_t r);
    grant_t g;
    int i;
    g = '{default: '0};
    for (i = 0; i < seg_cnt; i++)
      if (seg_tbl[i].kind != KindFree && seg_tbl[i].tag == r.tag) break;
    if (i >= seg_cnt) begin
      g.status = StatusBadTag;
      return g;
    end
    g.status = StatusOk;
    g.size = seg_tbl[i].len;
    g.offset = seg_tbl[i].start + seg_tbl[i].pad;
    g.tag = r.tag;
    seg_tbl[i].kind = KindFree;
    seg_tbl[i].pad = '0;
    if (i > 0 && seg_tbl[i-1].kind == KindFree) begin
      merge_next(i - 1);
      i--;
    end
    if (i + 1 < seg_cnt && seg_tbl[i+1].kind == KindFree) merge_next(i);
    used_b -= g.size;
    return g;
  endfunction

  // predict at queue time; items are taken in order and config only changes when idle
  function automatic void push_req(alloc_req_t r);
    grant_t g;
    g = (r.op == OpFree) ? release_seg(r) : place_alloc(r);
    if (g.status == StatusOk) begin
      if (r.op == OpAlloc) live_tags.push_back(g.tag);
      else
        foreach (live_tags[j])
          if (live_tags[j] == r.tag) begin
            live_tags.delete(j);
            break;
          end
    end
    pending_q.push_back(r);
    grant_q.push_back(g);
  endfunction

  function automatic alloc_req_t mk(logic op, logic [31:0] sz, logic [31:0] al,
                                    logic [2:0] k, logic [31:0] t);
    alloc_req_t r;
    r.op = op; r.size = sz; r.align = al; r.kind = k; r.tag = t;
    return r;
  endfunction

  function automatic alloc_req_t rand_req();
    alloc_req_t r;
    bit [63:0] span;
    int unsigned p;
    r.op = ($urandom_range(0, 99) < 42) ? OpFree : OpAlloc;
    r.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    p = $urandom_range(0, 19);
    r.align = (p == 0) ? $urandom : (p == 1) ? 32'd0 : 32'd1 << $urandom_range(0, 7);
    span = (64'(blk_bytes) >> 5) + 1;
    p = $urandom_range(0, 29);
    if (p == 0) r.size = $urandom;
    else if (p == 1) r.size = 32'd0;
    else r.size = 32'(64'd1 + ({$urandom, $urandom} % span));
    p = $urandom_range(0, 9);
    if (live_tags.size() != 0 && p < 8) r.tag = live_tags[$urandom_range(0, live_tags.size() - 1)];
    else if (p == 8) r.tag = $urandom;
    else r.tag = $urandom_range(0, tag_next + 2);
    return r;
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || grant_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegBlockSize) begin
      blk_bytes = val;
      reset_table();
    end else page_gran = val[PgW-1:0];
  endtask

  // driver
  always @(negedge clk_i) begin
    logic go;
    go = !in_valid_i || taken;
    if (go) begin
      if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
        alloc_req_t r;
        r = pending_q.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= r.op;
        req_size_i <= r.size;
        req_align_i <= r.align;
        kind_i <= r.kind;
        free_tag_i <= r.tag;
      end else in_valid_i <= 1'b0;
    end
    out_ready_i <= calm || $urandom_range(0, 99) >= 12;
  end

  // monitor
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    calm <= cycle_cnt > 20000 && cycle_cnt < 40000;
    taken <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      grant_cnt <= grant_cnt + 1;
      if (grant_q.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, status_o);
        err_cnt <= err_cnt + 1;
      end else begin
        grant_t e;
        e = grant_q.pop_front();
        if (e.status == StatusOk) ok_cnt <= ok_cnt + 1;
        if (e.status == StatusFull) full_cnt <= full_cnt + 1;
        if (status_o !== e.status || granted_offset_o !== e.offset ||
            granted_size_o !== e.size || granted_tag_o !== e.tag) begin
          $display("%0t: expected st %0d off %h size %h tag %h, got st %0d off %h size %h tag %h",
                   $time, e.status, e.offset, e.size, e.tag, status_o, granted_offset_o,
                   granted_size_o, granted_tag_o);
          err_cnt <= err_cnt + 1;
        end
      end
    end
    if (cycle_cnt >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [31:0] sizes[6];
    logic [31:0] grans[6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0; operation_i = 1'b0; req_size_i = '0; req_align_i = '0;
    kind_i = '0; free_tag_i = '0; out_ready_i = 1'b0;
    cycle_cnt = 0; err_cnt = 0; grant_cnt = 0; ok_cnt = 0; full_cnt = 0;
    taken = 1'b0; calm = 1'b0;
    blk_bytes = BlockSizeReset;
    page_gran = PageGranReset;
    reset_table();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: bad sizes and kinds, exact fill, unknown tags, odd aligns
    push_req(mk(OpAlloc, 32'd0, 32'd1, KindBuffer, 0));
    push_req(mk(OpAlloc, 32'd16, 32'd1, 3'd0, 0));
    push_req(mk(OpAlloc, 32'd16, 32'd1, 3'd7, 0));
    push_req(mk(OpAlloc, 32'hFFFF_FFFF, 32'h8000_0000, KindImage, 0));
    push_req(mk(OpAlloc, BlockSizeReset, 32'd0, KindOptimal, 0));
    push_req(mk(OpAlloc, 32'd1, 32'd1, KindBuffer, 0));
    push_req(mk(OpFree, 0, 0, 0, 32'd0));
    push_req(mk(OpFree, 0, 0, 0, 32'd0));
    push_req(mk(OpFree, 0, 0, 0, 32'hFFFF_FFFF));
    push_req(mk(OpAlloc, 32'd100, 32'd12, KindBuffer, 0));
    push_req(mk(OpAlloc, 32'd100, 32'h8000_0000, KindImage, 0));
    push_req(mk(OpAlloc, 32'd7, 32'd6, KindLinear, 0));
    push_req(mk(OpAlloc, 32'hAAAA_AAAA, 32'h5555_5555, KindOptimal, 0));
    push_req(mk(OpFree, 0, 0, 0, 32'd1));
    push_req(mk(OpFree, 0, 0, 0, 32'd2));
    push_req(mk(OpFree, 0, 0, 0, 32'd3));
    push_req(mk(OpFree, 0, 0, 0, 32'h5555_5555));
    drain();

    sizes = '{32'd65536, 32'hFFFF_FFFF, 32'd1, 32'd8192, 32'd1000000, 32'd4096};
    grans = '{32'd4096, 32'hFFF0_0000, 32'd0, 32'd24, 32'd256, 32'd1};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegBlockSize, sizes[ph]);
      write_reg(RegPageGran, grans[ph]);
      live_tags.delete();
      // fill the table to its limit with small allocations
      if (ph == 0 || ph == 3)
        for (int j = 0; j < 68; j++)
          push_req(mk(OpAlloc, 32'($urandom_range(1, 64)), 32'd1 << $urandom_range(0, 3),
                      3'($urandom_range(1, 4)), 0));
      for (int j = 0; j < 133; j++) begin
        if (j == 70) drain();
        push_req(rand_req());
      end
      drain();
    end

    $display("covered %0d results (%0d ok, %0d table full) over six block and page settings",
             grant_cnt, ok_cnt, full_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ffsa_pkg.sv
design/ffsa_ram.sv
design/ffsa_alu.sv
design/first_fit_segment_allocator.sv
design/ffsa_checker.sv
tb/tb_first_fit_segment_allocator.sv
